@@ hdl/arpc_pkg.sv @@
package arpc_pkg;

    // cache geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx LAST_IDX = t_idx'(TABLE_ENTRIES - 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_OWN_IP      = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_SUBNET_MASK = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_GATEWAY_IP  = t_cfg_idx'(2);

    // item kinds and opcodes
    localparam logic        CMD_PACKET  = 1'b0;
    localparam logic        CMD_RESOLVE = 1'b1;
    localparam logic [15:0] OP_REQUEST  = 16'd1;

    typedef struct packed {
        logic        cmd;
        logic        complete;
        logic [15:0] opcode;
        logic [31:0] src_ip;
        logic [47:0] src_mac;
        logic [31:0] tgt_ip;
        logic [31:0] dest_ip;
    } t_in;

    typedef struct packed {
        logic        dropped;
        logic        found;
        logic [47:0] mac;
        logic [31:0] next_hop_ip;
        logic        send_request;
        logic        send_reply;
        logic [47:0] reply_mac;
        logic [31:0] reply_ip;
        logic        wake_waiter;
    } t_out;

    // table write request
    typedef struct packed {
        logic        en;
        t_idx        addr;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_tbl_wr;

endpackage

@@ hdl/arpc_table.sv @@
module arpc_table
    import arpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_tbl_wr                  i_wr,
    input  t_idx                     i_rd_addr,
    output logic [31:0]              o_rd_ip,
    output logic [47:0]              o_rd_mac,
    output logic [TABLE_ENTRIES-1:0] o_valid
);

    logic [31:0]              r_mem_ip  [TABLE_ENTRIES];
    logic [47:0]              r_mem_mac [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [31:0]              r_rd_ip;
    logic [47:0]              r_rd_mac;

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // entry storage, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_ip[i_wr.addr]  <= i_wr.ip;
            r_mem_mac[i_wr.addr] <= i_wr.mac;
        end
        r_rd_ip  <= r_mem_ip[i_rd_addr];
        r_rd_mac <= r_mem_mac[i_rd_addr];
    end

    assign o_rd_ip  = r_rd_ip;
    assign o_rd_mac = r_rd_mac;
    assign o_valid  = r_valid;

endmodule

@@ hdl/arp_cache_engine.sv @@
// arp cache engine: ipv4-to-mac cache with one pending resolve
// sequence: a short packet goes from accept straight to the finish state; every other
// request first scans the table one entry per cycle through the table's single
// registered read port, then finishes; the result is registered in the finish state
// flow: one request at a time, the next accepted the cycle after the result loads;
// a held result waits
// reset: synchronous active low, clears config, valid bits, pending mark, output valid
module arp_cache_engine
    import arpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state      r_state;
    t_in         r_item;
    logic [31:0] r_key;
    logic [31:0] r_own_ip;
    logic [31:0] r_mask;
    logic [31:0] r_gateway;
    logic        r_pending;
    logic [31:0] r_pending_ip;

    // scan control
    t_idx        r_addr;
    logic        r_issue;
    logic        r_chk;
    t_idx        r_chk_idx;
    logic        r_hit;
    t_idx        r_hit_idx;
    logic [47:0] r_hit_mac;
    logic        r_empty;
    t_idx        r_empty_idx;

    logic        r_out_valid;
    t_out        r_out;

    logic [31:0]              rd_ip;
    logic [47:0]              rd_mac;
    logic [TABLE_ENTRIES-1:0] valid;
    t_tbl_wr                  tbl_wr;
    logic [31:0]              hop;
    logic                     chk_valid;
    logic                     chk_hit;
    logic                     out_free;
    logic                     learn;
    t_out                     result;

    arpc_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_addr (r_addr),
        .o_rd_ip   (rd_ip),
        .o_rd_mac  (rd_mac),
        .o_valid   (valid)
    );

    // next hop: gateway for off-subnet destinations
    assign hop = ((i_in_data.dest_ip & r_mask) != (r_own_ip & r_mask)) ?
                 r_gateway : i_in_data.dest_ip;

    // shared compare against the entry read last cycle
    assign chk_valid = valid[r_chk_idx];
    assign chk_hit   = r_chk && chk_valid && (rd_ip == r_key);

    assign out_free = !r_out_valid || !i_out_stall;
    assign learn    = (r_state == ST_FINISH) && out_free &&
                      (r_item.cmd == CMD_PACKET) && r_item.complete;

    // learn: matching slot, else first empty slot, else slot 0
    always_comb begin
        tbl_wr.en   = learn;
        tbl_wr.addr = r_hit ? r_hit_idx : (r_empty ? r_empty_idx : '0);
        tbl_wr.ip   = r_item.src_ip;
        tbl_wr.mac  = r_item.src_mac;
    end

    // result assembly
    always_comb begin
        result = '0;
        if (r_item.cmd == CMD_PACKET) begin
            if (!r_item.complete) begin
                result.dropped = 1'b1;
            end else begin
                if (r_item.opcode == OP_REQUEST && r_item.tgt_ip == r_own_ip) begin
                    result.send_reply = 1'b1;
                    result.reply_mac  = r_item.src_mac;
                    result.reply_ip   = r_item.src_ip;
                end
                result.wake_waiter = r_pending && (r_pending_ip == r_item.src_ip);
            end
        end else begin
            result.next_hop_ip  = r_key;
            result.found        = r_hit;
            result.mac          = r_hit ? r_hit_mac : 48'd0;
            result.send_request = !r_hit;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= '0;
            r_mask    <= '0;
            r_gateway <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OWN_IP:      r_own_ip  <= i_cfg_data;
                CFG_SUBNET_MASK: r_mask    <= i_cfg_data;
                CFG_GATEWAY_IP:  r_gateway <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_issue      <= 1'b0;
            r_chk        <= 1'b0;
            r_hit        <= 1'b0;
            r_empty      <= 1'b0;
            r_pending    <= 1'b0;
            r_pending_ip <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // result taken; a finishing request reloads it below
            if (r_out_valid && !i_out_stall && r_state != ST_FINISH) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_item    <= i_in_data;
                        r_key     <= (i_in_data.cmd == CMD_PACKET) ? i_in_data.src_ip : hop;
                        r_addr    <= '0;
                        r_issue   <= 1'b1;
                        r_chk     <= 1'b0;
                        r_hit     <= 1'b0;
                        r_empty   <= 1'b0;
                        if (i_in_data.cmd == CMD_PACKET && !i_in_data.complete) begin
                            r_state <= ST_FINISH;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // issue one read per cycle
                    r_chk     <= r_issue;
                    r_chk_idx <= r_addr;
                    if (r_issue) begin
                        if (r_addr == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + t_idx'(1);
                        end
                    end
                    // keep the lowest hit and the lowest empty slot
                    if (chk_hit && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_chk_idx;
                        r_hit_mac <= rd_mac;
                    end
                    if (r_chk && !chk_valid && !r_empty) begin
                        r_empty     <= 1'b1;
                        r_empty_idx <= r_chk_idx;
                    end
                    if (r_chk && r_chk_idx == LAST_IDX) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_out       <= result;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                        if (r_item.cmd == CMD_PACKET) begin
                            if (result.wake_waiter) begin
                                r_pending <= 1'b0;
                            end
                        end else if (!r_hit) begin
                            r_pending    <= 1'b1;
                            r_pending_ip <= r_key;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
